### rtl/core/rpt_pkg.sv
package rpt_pkg;

    // Fixed limits of the block
    localparam int MAX_SLICES   = 360;
    localparam int FRAC_BITS    = 12;
    localparam int MIN_RADIUS   = ((1 << FRAC_BITS) + 50) / 100;
    localparam int MIN_INNER    = ((1 << FRAC_BITS) + 100) / 200;
    localparam int MIN_SLICES   = 3;

    localparam int NW           = 9;    // slice count / index width
    localparam int LW           = 15;   // length register width
    localparam int PW           = 32;   // phase width, 2^32 per turn
    localparam int CW           = 34;   // CORDIC x/y width, Q1.30 plus headroom
    localparam int ZW           = 33;   // CORDIC angle width
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_CYCLES   = PW / 2;
    localparam int MW           = CW + LW + 1;  // product width

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef enum logic [1:0] {
        SHAPE_CONE = 2'd0,
        SHAPE_CYL  = 2'd1,
        SHAPE_TUBE = 2'd2
    } shape_t;

    typedef enum logic [2:0] {
        REG_SHAPE  = 3'd0,
        REG_OUTER  = 3'd1,
        REG_INNER  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_SLICES = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_EMIT_I,
        DIV_EMIT_J
    } div_state_t;

    // One CORDIC cell's worth of state
    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
        logic                 second;
        logic                 bad;
    } cell_t;

    // Unit vectors of a slice and its neighbor
    typedef struct packed {
        logic signed [CW-1:0] ci;
        logic signed [CW-1:0] si;
        logic signed [CW-1:0] cj;
        logic signed [CW-1:0] sj;
        logic                 bad;
    } ring_t;

    // Effective geometry after clamping and swapping
    typedef struct packed {
        logic [1:0]    mode;
        logic [LW-1:0] ro;
        logic [LW-1:0] ri;
        logic [LW-1:0] hh;
    } geom_t;

    // Vertex code bits: {center, use_j, inner, top}
    localparam logic [3:0] CONE_SEQ [6] = '{
        4'b0000, 4'b0100, 4'b1001, 4'b0100, 4'b0000, 4'b1000
    };
    localparam logic [3:0] CYL_SEQ [12] = '{
        4'b0101, 4'b0001, 4'b1001, 4'b0000, 4'b0100, 4'b1000,
        4'b0100, 4'b0000, 4'b0101, 4'b0101, 4'b0000, 4'b0001
    };
    localparam logic [3:0] TUBE_SEQ [24] = '{
        4'b0111, 4'b0101, 4'b0011, 4'b0011, 4'b0101, 4'b0001,
        4'b0010, 4'b0000, 4'b0110, 4'b0110, 4'b0000, 4'b0100,
        4'b0100, 4'b0000, 4'b0101, 4'b0101, 4'b0000, 4'b0001,
        4'b0110, 4'b0111, 4'b0010, 4'b0010, 4'b0111, 4'b0011
    };

    // Rotation angles in 2^32-per-turn units
    function automatic logic signed [ZW-1:0] atan_at(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 33'sh020000000;
            1:  a = 33'sh012E4051D;
            2:  a = 33'sh009FB385B;
            3:  a = 33'sh0051111D4;
            4:  a = 33'sh0028B0D43;
            5:  a = 33'sh00145D7E1;
            6:  a = 33'sh000A2F61E;
            7:  a = 33'sh000517C55;
            8:  a = 33'sh00028BE53;
            9:  a = 33'sh000145F2E;
            10: a = 33'sh0000A2F98;
            11: a = 33'sh0000517CC;
            12: a = 33'sh000028BE6;
            13: a = 33'sh0000145F3;
            14: a = 33'sh000000A2F9;
            15: a = 33'sh00000517C;
            16: a = 33'sh0000028BE;
            17: a = 33'sh00000145F;
            18: a = 33'sh000000A2F;
            19: a = 33'sh000000517;
            20: a = 33'sh00000028B;
            21: a = 33'sh000000145;
            22: a = 33'sh0000000A2;
            23: a = 33'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/revolved_primitive_tessellator.sv
// Revolved primitive tessellator: each slice index taken on the s_ channel yields that
// slice's triangle vertices on the m_ channel, one vertex a cycle unless the receiver
// stalls: 6 for a cone, 12 for a cylinder, 24 for a tube, or one zero vertex flagged in
// tuser when the index is not below the slice count. A slice's two angles come from a
// two-lane divider, then run through a chain of 24 CORDIC cells. At most two items sit
// between the input and the vertex sequencer, and no new index is taken while the
// divider is busy. Write registers only while idle.
module revolved_primitive_tessellator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // slice_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // pos_x, pos_y, pos_z
    output logic        m_tlast,    // last_vertex
    output logic        m_tuser     // bad_slice
);
    import rpt_pkg::*;

    logic [1:0]    shape_reg;
    logic [LW-1:0] outer_reg, inner_reg, height_reg;
    logic [NW-1:0] slices_reg;
    geom_t         geom_reg, geom_next;
    logic [NW-1:0] n_eff, idx, nb;
    logic          bad, accept, div_busy, pop, push;
    logic [1:0]    inflight_reg;
    logic [LW-1:0] ro, ri, h;
    logic [LW:0]   h_sum;
    cell_t         chain [CORDIC_STEPS+1];
    ring_t         ring;
    logic signed [CW-1:0] ci_reg, si_reg, c_end, s_end;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg  <= SHAPE_CYL;
            outer_reg  <= 15'd4096;
            inner_reg  <= 15'd2048;
            height_reg <= 15'd4096;
            slices_reg <= 9'd12;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHAPE:  shape_reg  <= cfg_wdata[1:0];
                REG_OUTER:  outer_reg  <= cfg_wdata;
                REG_INNER:  inner_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                REG_SLICES: slices_reg <= cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // Effective slice count and geometry
    always_comb begin
        n_eff = slices_reg;
        if (slices_reg < NW'(MIN_SLICES)) n_eff = NW'(MIN_SLICES);
        if (slices_reg > NW'(MAX_SLICES)) n_eff = NW'(MAX_SLICES);
        ro = (outer_reg < LW'(MIN_RADIUS)) ? LW'(MIN_RADIUS) : outer_reg;
        ri = (inner_reg < LW'(MIN_INNER)) ? LW'(MIN_INNER) : inner_reg;
        h  = (height_reg < LW'(MIN_RADIUS)) ? LW'(MIN_RADIUS) : height_reg;
        h_sum = {1'b0, h} + 1'b1;
        geom_next.mode = shape_reg;
        geom_next.hh   = h_sum[LW:1];
        geom_next.ro   = ro;
        geom_next.ri   = ri;
        if (shape_reg == SHAPE_TUBE && ri > ro) begin
            geom_next.ro = ri;
            geom_next.ri = ro;
        end
    end

    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
    end

    // Input acceptance
    assign idx      = s_tdata[NW-1:0];
    assign bad      = idx >= n_eff;
    assign nb       = (idx + 1'b1 == n_eff) ? '0 : idx + 1'b1;
    assign s_tready = !div_busy && (inflight_reg < 2'd2);
    assign accept   = s_tvalid && s_tready;

    // Items between acceptance and the vertex sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + {1'b0, accept} - {1'b0, pop};
        end
    end

    rpt_phase_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .idx     (idx),
        .nb      (nb),
        .cnt     (n_eff),
        .bad     (bad),
        .busy    (div_busy),
        .inj     (chain[0])
    );

    // CORDIC chain
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rpt_cordic_cell #(.STAGE(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cin     (chain[g]),
            .cout    (chain[g+1])
        );
    end

    // Quadrant fold at the end of the chain
    always_comb begin
        case (chain[CORDIC_STEPS].quad)
            2'd0: begin c_end = chain[CORDIC_STEPS].x;  s_end = chain[CORDIC_STEPS].y;  end
            2'd1: begin c_end = -chain[CORDIC_STEPS].y; s_end = chain[CORDIC_STEPS].x;  end
            2'd2: begin c_end = -chain[CORDIC_STEPS].x; s_end = -chain[CORDIC_STEPS].y; end
            default: begin
                c_end = chain[CORDIC_STEPS].y;
                s_end = -chain[CORDIC_STEPS].x;
            end
        endcase
    end

    // Pair up slice and neighbor vectors
    always_ff @(posedge aclk) begin
        if (chain[CORDIC_STEPS].valid && !chain[CORDIC_STEPS].second) begin
            ci_reg <= c_end;
            si_reg <= s_end;
        end
    end

    assign push = chain[CORDIC_STEPS].valid && chain[CORDIC_STEPS].second;
    assign ring = '{ci: ci_reg, si: si_reg, cj: c_end, sj: s_end,
                    bad: chain[CORDIC_STEPS].bad};

    rpt_vertex_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (ring),
        .geom      (geom_reg),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/core/rpt_phase_div.sv
module rpt_phase_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [rpt_pkg::NW-1:0] idx,
    input  logic [rpt_pkg::NW-1:0] nb,
    input  logic [rpt_pkg::NW-1:0] cnt,
    input  logic                   bad,
    output logic                   busy,
    output rpt_pkg::cell_t         inj
);
    import rpt_pkg::*;

    localparam int SCW = $clog2(DIV_CYCLES);

    div_state_t          state_reg, state_next;
    logic [SCW-1:0]      step_reg;
    logic [NW-1:0]       rem_i_reg, rem_j_reg, den_reg;
    logic [PW-1:0]       q_i_reg, q_j_reg;
    logic                bad_reg;
    logic [NW-1:0]       rem_i_next, rem_j_next;
    logic [1:0]          bits_i, bits_j;
    logic [PW-1:0]       phase;

    // Two restoring steps: remainder stays below the divisor
    function automatic logic [NW+1:0] two_steps(input logic [NW-1:0] r,
                                                input logic [NW-1:0] d);
        logic [NW:0]   t;
        logic [NW-1:0] rr;
        logic [1:0]    b;
        rr = r;
        b  = '0;
        for (int k = 0; k < 2; k++) begin
            t = {rr, 1'b0};
            if (t >= {1'b0, d}) begin
                rr = NW'(t - {1'b0, d});
                b  = {b[0], 1'b1};
            end else begin
                rr = t[NW-1:0];
                b  = {b[0], 1'b0};
            end
        end
        return {rr, b};
    endfunction

    assign {rem_i_next, bits_i} = two_steps(rem_i_reg, den_reg);
    assign {rem_j_next, bits_j} = two_steps(rem_j_reg, den_reg);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and injection into the chain
    always_comb begin
        state_next = state_reg;
        busy       = 1'b1;
        phase      = q_i_reg;
        inj        = '0;
        case (state_reg)
            DIV_IDLE: begin
                busy = 1'b0;
                if (start) state_next = DIV_RUN;
            end
            DIV_RUN: begin
                if (step_reg == SCW'(DIV_CYCLES - 1)) state_next = DIV_EMIT_I;
            end
            DIV_EMIT_I: begin
                inj.valid  = 1'b1;
                state_next = DIV_EMIT_J;
            end
            DIV_EMIT_J: begin
                inj.valid  = 1'b1;
                inj.second = 1'b1;
                phase      = q_j_reg;
                state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
        inj.x    = CORDIC_GAIN;
        inj.y    = '0;
        inj.z    = ZW'({1'b0, phase[PW-3:0]});
        inj.quad = phase[PW-1:PW-2];
        inj.bad  = bad_reg;
    end

    // Datapath: two quotients, two bits a cycle
    always_ff @(posedge aclk) begin
        if (state_reg == DIV_IDLE && start) begin
            rem_i_reg <= bad ? '0 : idx;
            rem_j_reg <= bad ? '0 : nb;
            den_reg   <= cnt;
            bad_reg   <= bad;
            step_reg  <= '0;
        end else if (state_reg == DIV_RUN) begin
            rem_i_reg <= rem_i_next;
            rem_j_reg <= rem_j_next;
            q_i_reg   <= {q_i_reg[PW-3:0], bits_i};
            q_j_reg   <= {q_j_reg[PW-3:0], bits_j};
            step_reg  <= step_reg + 1'b1;
        end
    end

endmodule

### rtl/core/rpt_cordic_cell.sv
module rpt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rpt_pkg::cell_t cin,
    output rpt_pkg::cell_t cout
);
    import rpt_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = atan_at(STAGE);

    logic signed [CW-1:0] xs, ys;

    assign xs = cin.x >>> STAGE;
    assign ys = cin.y >>> STAGE;

    // One micro-rotation toward zero angle; only valid clears at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cout.valid <= 1'b0;
        end else begin
            cout.valid <= cin.valid;
        end
        if (!cin.z[ZW-1]) begin
            cout.x <= cin.x - ys;
            cout.y <= cin.y + xs;
            cout.z <= cin.z - ANGLE;
        end else begin
            cout.x <= cin.x + ys;
            cout.y <= cin.y - xs;
            cout.z <= cin.z + ANGLE;
        end
        cout.quad   <= cin.quad;
        cout.second <= cin.second;
        cout.bad    <= cin.bad;
    end

endmodule

### rtl/core/rpt_vertex_seq.sv
module rpt_vertex_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rpt_pkg::ring_t push_data,
    input  rpt_pkg::geom_t geom,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [47:0]    m_tdata,   // pos_x, pos_y, pos_z
    output logic           m_tlast,   // last_vertex
    output logic           m_tuser    // bad_slice
);
    import rpt_pkg::*;

    // Two-entry buffer of finished slices
    ring_t       fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;

    ring_t       cur_reg;
    logic        cur_valid_reg;
    logic [4:0]  k_reg;

    logic                 p_valid_reg, p_last_reg, p_bad_reg, p_center_reg;
    logic signed [MW-1:0] p_x_reg, p_z_reg;
    logic signed [15:0]   p_y_reg;

    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    logic        m_last_reg, m_bad_reg;

    logic        en, issue, last_k;
    logic [4:0]  count;
    logic [3:0]  code;
    logic [LW-1:0] r;
    logic signed [CW-1:0] c, s;
    logic signed [15:0] y_val;

    function automatic logic signed [15:0] round_sat(input logic signed [MW-1:0] p);
        logic signed [MW-1:0] v;
        v = (p + MW'(64'sd536870912)) >>> 30;
        if (v > MW'(64'sd32767)) return 16'sh7FFF;
        if (v < -MW'(64'sd32768)) return 16'sh8000;
        return v[15:0];
    endfunction

    // Vertex count and code of the current step
    always_comb begin
        case (geom.mode)
            SHAPE_CONE: begin
                count = 5'd6;
                code  = CONE_SEQ[k_reg[2:0] < 3'd6 ? k_reg[2:0] : 3'd0];
            end
            SHAPE_TUBE: begin
                count = 5'd24;
                code  = TUBE_SEQ[k_reg < 5'd24 ? k_reg : 5'd0];
            end
            default: begin
                count = 5'd12;
                code  = CYL_SEQ[k_reg[3:0] < 4'd12 ? k_reg[3:0] : 4'd0];
            end
        endcase
        if (cur_reg.bad) begin
            count = 5'd1;
            code  = 4'b1000;
        end
    end

    assign en     = !m_valid_reg || m_tready;
    assign issue  = en && cur_valid_reg;
    assign last_k = (k_reg == count - 5'd1);
    assign pop    = (fill_reg != 2'd0) && (!cur_valid_reg || (issue && last_k));

    // Operand selection for the vertex being issued
    always_comb begin
        r     = code[1] ? geom.ri : geom.ro;
        c     = code[2] ? cur_reg.cj : cur_reg.ci;
        s     = code[2] ? cur_reg.sj : cur_reg.si;
        y_val = code[0] ? $signed({1'b0, geom.hh}) : -$signed({1'b0, geom.hh});
        if (cur_reg.bad) y_val = '0;
    end

    // Control: buffer pointers, current slice, pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            fill_reg      <= '0;
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                cur_valid_reg <= 1'b1;
                k_reg         <= '0;
            end else if (issue) begin
                if (last_k) begin
                    cur_valid_reg <= 1'b0;
                    k_reg         <= '0;
                end else begin
                    k_reg <= k_reg + 5'd1;
                end
            end
            if (en) begin
                p_valid_reg <= issue;
                m_valid_reg <= p_valid_reg;
            end
        end
    end

    // Payload: buffer, products, rounding into the output register
    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= push_data;
        if (pop)  cur_reg <= fifo_reg[rd_ptr_reg];
        if (en) begin
            p_x_reg      <= $signed({1'b0, r}) * c;
            p_z_reg      <= $signed({1'b0, r}) * s;
            p_y_reg      <= y_val;
            p_last_reg   <= last_k;
            p_bad_reg    <= cur_reg.bad;
            p_center_reg <= code[3];
            m_data_reg[31:16] <= p_y_reg;
            m_data_reg[15:0]  <= p_center_reg ? 16'h0000 : round_sat(p_x_reg);
            m_data_reg[47:32] <= p_center_reg ? 16'h0000 : round_sat(p_z_reg);
            m_last_reg <= p_last_reg;
            m_bad_reg  <= p_bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

endmodule

### test/rpt_vertex_checker.sv
`timescale 1ns / 1ps

module rpt_vertex_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // slice_index
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,    // pos_x, pos_y, pos_z
    input  logic        m_tlast,    // last_vertex
    input  logic        m_tuser,    // bad_slice
    output int          fail_count,
    output int          pending
);
    import rpt_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        last;
        logic        bad;
    } vertex_t;

    localparam longint GAIN = 64'h26DD3B6A;
    localparam longint ANGLE [24] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    // Shadow copy of the registers
    logic [1:0]  cur_shape;
    logic [14:0] cur_outer, cur_inner, cur_height;
    logic [8:0]  cur_slices;

    vertex_t expected_vertices [$];

    // cos/sin of 2*pi*n/cnt in Q1.30 by a 24-step rotation
    task automatic turn_vector(input longint n, input longint cnt,
                               output longint c, output longint s);
        longint unsigned phase;
        longint x, y, z, nx;
        logic [1:0] q;
        phase = (longint'(n) << 32) / cnt;
        q = phase[31:30];
        z = longint'(phase & 64'h3FFFFFFF);
        x = GAIN;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ANGLE[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ANGLE[i];
            end
            x = nx;
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [15:0] scale_len(input longint r, input longint u);
        longint v;
        v = (r * u + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic vertex_t ring_point(input longint r, input longint c,
                                           input longint s, input longint y);
        vertex_t p;
        p.x = scale_len(r, c);
        p.y = y[15:0];
        p.z = scale_len(r, s);
        p.last = 1'b0;
        p.bad = 1'b0;
        return p;
    endfunction

    // Expand one slice into its draw-order vertex list
    task automatic predict_slice(input logic [8:0] idx);
        longint n, ro, ri, h, hh, ci, si, cj, sj, nb, t;
        vertex_t v [$];
        vertex_t zero_v;
        vertex_t top, bot, ti, tj, bi, bj, tii, tij, bii, bij;
        n  = cur_slices;
        ro = cur_outer;
        ri = cur_inner;
        h  = cur_height;
        if (n < MIN_SLICES) n = MIN_SLICES;
        if (n > MAX_SLICES) n = MAX_SLICES;
        if (ro < MIN_RADIUS) ro = MIN_RADIUS;
        if (ri < MIN_INNER) ri = MIN_INNER;
        if (h < MIN_RADIUS) h = MIN_RADIUS;
        hh = (h + 1) >>> 1;
        if (idx >= n) begin
            zero_v = '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
            expected_vertices = {expected_vertices, zero_v};
            return;
        end
        nb = (idx + 1 == n) ? 0 : idx + 1;
        turn_vector(idx, n, ci, si);
        turn_vector(nb, n, cj, sj);
        top = '{16'd0, hh[15:0], 16'd0, 1'b0, 1'b0};
        bot = '{16'd0, -hh[15:0], 16'd0, 1'b0, 1'b0};
        if (cur_shape == SHAPE_TUBE && ri > ro) begin
            t = ri; ri = ro; ro = t;
        end
        ti  = ring_point(ro, ci, si, hh);
        tj  = ring_point(ro, cj, sj, hh);
        bi  = ring_point(ro, ci, si, -hh);
        bj  = ring_point(ro, cj, sj, -hh);
        tii = ring_point(ri, ci, si, hh);
        tij = ring_point(ri, cj, sj, hh);
        bii = ring_point(ri, ci, si, -hh);
        bij = ring_point(ri, cj, sj, -hh);
        if (cur_shape == SHAPE_CONE) begin
            v = '{bi, bj, top, bj, bi, bot};
        end else if (cur_shape == SHAPE_TUBE) begin
            v = '{tij, tj, tii, tii, tj, ti,   bii, bi, bij, bij, bi, bj,
                  bj, bi, tj, tj, bi, ti,      bij, tij, bii, bii, tij, tii};
        end else begin
            // cylinder, also the unused shape code
            v = '{tj, ti, top, bi, bj, bot, bj, bi, tj, tj, bi, ti};
        end
        v[v.size() - 1].last = 1'b1;
        expected_vertices = {expected_vertices, v};
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_shape  <= SHAPE_CYL;
            cur_outer  <= 15'd4096;
            cur_inner  <= 15'd2048;
            cur_height <= 15'd4096;
            cur_slices <= 9'd12;
            fail_count <= 0;
            pending    <= 0;
            expected_vertices.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SHAPE:  cur_shape  <= cfg_wdata[1:0];
                    REG_OUTER:  cur_outer  <= cfg_wdata;
                    REG_INNER:  cur_inner  <= cfg_wdata;
                    REG_HEIGHT: cur_height <= cfg_wdata;
                    REG_SLICES: cur_slices <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
            // accepted slice index
            if (s_tvalid && s_tready) predict_slice(s_tdata[8:0]);
            // accepted vertex
            if (m_tvalid && m_tready) begin
                if (expected_vertices.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected vertex %h last=%b bad=%b",
                                 m_tdata, m_tlast, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    vertex_t e;
                    e = expected_vertices.pop_front();
                    if (m_tdata[15:0] !== e.x || m_tdata[31:16] !== e.y ||
                        m_tdata[47:32] !== e.z || m_tlast !== e.last ||
                        m_tuser !== e.bad) begin
                        if (fail_count < 10)
                            $display({"ERROR: vertex exp x=%h y=%h z=%h last=%b bad=%b",
                                      " got x=%h y=%h z=%h last=%b bad=%b"},
                                     e.x, e.y, e.z, e.last, e.bad,
                                     m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                     m_tlast, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_vertices.size();
        end
    end

endmodule

### test/tb_revolved_primitive_tessellator.sv
`timescale 1ns / 1ps

module tb_revolved_primitive_tessellator;
    import rpt_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 80;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          burst_left;
    int          stall_mode;

    revolved_primitive_tessellator u_dut (.*);

    rpt_vertex_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: switches between free-running, random and heavy stall
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [14:0] shape, input logic [14:0] ro,
                                input logic [14:0] ri, input logic [14:0] h,
                                input logic [14:0] n);
        write_reg(REG_SHAPE, shape);
        write_reg(REG_OUTER, ro);
        write_reg(REG_INNER, ri);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SLICES, n);
        write_reg(REG_UNUSED, 15'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One slice index, sent in bursts separated by random gaps
    task automatic send_slice(input logic [8:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, idx};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int n;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SHAPE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        burst_left = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry: first, last and out-of-range slices
        send_slice(9'd0);
        send_slice(9'd11);
        send_slice(9'd12);
        send_slice(9'd511);
        drain();
        // Cone, fewest slices, largest lengths
        set_geometry(15'(SHAPE_CONE), 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd3);
        send_slice(9'd0); send_slice(9'd1); send_slice(9'd2); send_slice(9'd3);
        drain();
        // Tube with inner larger than outer
        set_geometry(15'(SHAPE_TUBE), 15'd1000, 15'd30000, 15'd5000, 15'd7);
        send_slice(9'd6); send_slice(9'd3);
        drain();
        // Tube with all lengths below their minimum, slice count clamped up
        set_geometry(15'(SHAPE_TUBE), 15'd0, 15'd0, 15'd0, 15'd0);
        send_slice(9'd2); send_slice(9'd3);
        drain();
        // Cylinder, most slices; slice count clamped down from the top
        set_geometry(15'(SHAPE_CYL), 15'd20000, 15'd100, 15'd1, 15'd511);
        send_slice(9'd0); send_slice(9'd359); send_slice(9'd360); send_slice(9'd90);
        drain();
        // Unused shape code acts as a cylinder
        set_geometry(15'h7FFF, 15'd4096, 15'd2048, 15'd8192, 15'd360);
        send_slice(9'd45); send_slice(9'd180); send_slice(9'd256);
        drain();

        // Random geometries, mostly valid slices
        repeat (12) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                            : $urandom_range(3, 40);
            set_geometry(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                         15'(n));
            if (n < 3) n = 3;
            if (n > MAX_SLICES) n = MAX_SLICES;
            repeat (32) begin
                if ($urandom_range(0, 9) == 0) send_slice(9'($urandom));
                else send_slice(9'($urandom_range(0, n - 1)));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
